FILE: hw/rtl/kwhm_pkg.sv
// ----------------------------------------------------------------------------
// kwhm_pkg
// Shared types and constants of the k-way heap merge: controller states,
// datapath operation codes and the status group the datapath reports back.
// ----------------------------------------------------------------------------
`default_nettype none

package kwhm_pkg;

  // fixed field widths
  localparam int RUN_W = 4;  // run number
  localparam int CFG_W = 5;  // runs-in-use register and report counter

  // one operation per cycle, issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PUSH_INIT,
    OP_SU_RD,
    OP_SU_CMP,
    OP_RPT,
    OP_FIN,
    OP_POP_RD,
    OP_POP_LD,
    OP_SD_RD,
    OP_SD_CMP
  } dp_op_e;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH,
    ST_SU_RD,
    ST_SU_CMP,
    ST_RPT,
    ST_FIN,
    ST_POP_RD,
    ST_POP_LD,
    ST_SD_RD,
    ST_SD_CMP
  } ctrl_state_e;

  // datapath flags seen by the controller
  typedef struct packed {
    logic push_ok;     // element present and heap not full
    logic idx_zero;    // hole has reached the root
    logic up_less;     // carried entry orders before its parent
    logic rpt_last;    // this report completes the fill phase (or merge phase)
    logic heap_empty;  // nothing left to pop
    logic last_pop;    // pop leaves the heap empty
    logic sd_stay;     // carried entry stays at the hole
    logic out_free;    // output slot can take a result this cycle
    logic done;        // finished result already produced
  } dp_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/kwhm_ram.sv
// ----------------------------------------------------------------------------
// kwhm_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kwhm_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read ports
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/kwhm_datapath.sv
// ----------------------------------------------------------------------------
// kwhm_datapath
// Heap storage, carried entry, hole index, counters and the output register.
// Executes one controller operation per cycle and reports status flags.
// ----------------------------------------------------------------------------
`default_nettype none

module kwhm_datapath #(
  parameter int MAX_RUNS   = 16,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [kwhm_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  wire logic [kwhm_pkg::RUN_W-1:0]   run_index_i,
  input  wire logic signed [VALUE_BITS-1:0] run_value_i,
  input  wire logic                         run_exhausted_i,
  input  wire logic                         out_stall_i,
  output logic                              out_valid_o,
  output logic signed [VALUE_BITS-1:0]      merged_value_o,
  output logic [kwhm_pkg::RUN_W-1:0]        source_run_o,
  output logic                              finished_o,
  input  wire kwhm_pkg::dp_op_e             op_i,
  output kwhm_pkg::dp_status_t              status_o
);

  import kwhm_pkg::*;

  localparam int IW = $clog2(MAX_RUNS);
  localparam int SW = $clog2(MAX_RUNS + 1);
  localparam int CW = IW + 2;
  localparam int EW = VALUE_BITS + RUN_W;
  localparam int NeedCapInt = (MAX_RUNS < (1 << CFG_W) - 1) ? MAX_RUNS : (1 << CFG_W) - 1;
  localparam logic [CFG_W-1:0] NeedCap = CFG_W'(NeedCapInt);

  // order by signed value, then by run number
  function automatic logic entry_lt(input logic [VALUE_BITS-1:0] av,
                                    input logic [RUN_W-1:0]      ar,
                                    input logic [VALUE_BITS-1:0] bv,
                                    input logic [RUN_W-1:0]      br);
    return ($signed(av) < $signed(bv)) || ((av == bv) && (ar < br));
  endfunction

  // control registers
  logic [CFG_W-1:0] cfg_q, cfg_d;
  logic [SW-1:0]    size_q, size_d;
  logic [CFG_W-1:0] rpt_q, rpt_d;
  logic             done_q, done_d;
  logic             out_valid_q, out_valid_d;

  // payload registers
  logic [IW-1:0]         idx_q, idx_d;
  logic [VALUE_BITS-1:0] cur_val_q, cur_val_d;
  logic [RUN_W-1:0]      cur_run_q, cur_run_d;
  logic                  exh_q, exh_d;
  logic [VALUE_BITS-1:0] out_val_q, out_val_d;
  logic [RUN_W-1:0]      out_run_q, out_run_d;
  logic                  out_fin_q, out_fin_d;

  // heap memory ports
  logic          we;
  logic [IW-1:0] waddr, raddr_a, raddr_b;
  logic [EW-1:0] wdata, rd_a, rd_b;

  logic [CFG_W-1:0]      need;
  logic [IW-1:0]         par_idx;
  logic [CW-1:0]         child_l, child_r, size_ext;
  logic                  l_ok, r_ok, pick_l, pick_r;
  logic [VALUE_BITS-1:0] a_val, b_val, best_val;
  logic [RUN_W-1:0]      a_run, b_run, best_run;

  kwhm_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_RUNS)
  ) u_heap_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // effective run count, clamped to 1..max
  always_comb begin
    if (cfg_q == '0) begin
      need = CFG_W'(1);
    end else if (cfg_q > NeedCap) begin
      need = NeedCap;
    end else begin
      need = cfg_q;
    end
  end

  // heap index arithmetic
  assign par_idx  = (idx_q - IW'(1)) >> 1;
  assign child_l  = {1'b0, idx_q, 1'b1};
  assign child_r  = child_l + CW'(1);
  assign size_ext = CW'(size_q);
  assign l_ok     = child_l < size_ext;
  assign r_ok     = child_r < size_ext;

  // sift-down child selection
  assign a_val    = rd_a[EW-1:RUN_W];
  assign a_run    = rd_a[RUN_W-1:0];
  assign b_val    = rd_b[EW-1:RUN_W];
  assign b_run    = rd_b[RUN_W-1:0];
  assign pick_l   = l_ok && entry_lt(a_val, a_run, cur_val_q, cur_run_q);
  assign best_val = pick_l ? a_val : cur_val_q;
  assign best_run = pick_l ? a_run : cur_run_q;
  assign pick_r   = r_ok && entry_lt(b_val, b_run, best_val, best_run);

  // status back to the controller
  always_comb begin
    status_o.push_ok    = !exh_q && (size_q != SW'(MAX_RUNS));
    status_o.idx_zero   = idx_q == '0;
    status_o.up_less    = entry_lt(cur_val_q, cur_run_q, a_val, a_run);
    status_o.rpt_last   = ((CFG_W + 1)'(rpt_q) + (CFG_W + 1)'(1)) >= (CFG_W + 1)'(need);
    status_o.heap_empty = size_q == '0;
    status_o.last_pop   = size_q == SW'(1);
    status_o.sd_stay    = !pick_l && !pick_r;
    status_o.out_free   = !out_valid_q || !out_stall_i;
    status_o.done       = done_q;
  end

  // operation decode
  always_comb begin
    cfg_d       = cfg_q;
    size_d      = size_q;
    rpt_d       = rpt_q;
    done_d      = done_q;
    out_valid_d = out_valid_q;
    idx_d       = idx_q;
    cur_val_d   = cur_val_q;
    cur_run_d   = cur_run_q;
    exh_d       = exh_q;
    out_val_d   = out_val_q;
    out_run_d   = out_run_q;
    out_fin_d   = out_fin_q;
    we          = 1'b0;
    waddr       = idx_q;
    wdata       = {cur_val_q, cur_run_q};
    raddr_a     = par_idx;
    raddr_b     = IW'(child_r);

    if (cfg_we_i) begin
      cfg_d = cfg_wdata_i;
    end
    // output transfer frees the slot
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (op_i)
      OP_LOAD: begin
        cur_val_d = run_value_i;
        cur_run_d = run_index_i;
        exh_d     = run_exhausted_i;
      end
      OP_PUSH_INIT: begin
        idx_d  = IW'(size_q);
        size_d = size_q + SW'(1);
      end
      OP_SU_RD: begin
        raddr_a = par_idx;
        we      = status_o.idx_zero;
      end
      OP_SU_CMP: begin
        we = 1'b1;
        if (status_o.up_less) begin
          wdata = rd_a;
          idx_d = par_idx;
        end
      end
      OP_RPT: begin
        if (rpt_q < need) begin
          rpt_d = rpt_q + CFG_W'(1);
        end
      end
      OP_FIN: begin
        out_valid_d = 1'b1;
        out_val_d   = '0;
        out_run_d   = '0;
        out_fin_d   = 1'b1;
        done_d      = 1'b1;
      end
      OP_POP_RD: begin
        raddr_a = '0;
        raddr_b = IW'(size_q - SW'(1));
      end
      OP_POP_LD: begin
        out_valid_d = 1'b1;
        out_val_d   = a_val;
        out_run_d   = a_run;
        out_fin_d   = 1'b0;
        cur_val_d   = b_val;
        cur_run_d   = b_run;
        size_d      = size_q - SW'(1);
        idx_d       = '0;
      end
      OP_SD_RD: begin
        raddr_a = IW'(child_l);
        raddr_b = IW'(child_r);
      end
      OP_SD_CMP: begin
        we = 1'b1;
        if (pick_r) begin
          wdata = rd_b;
          idx_d = IW'(child_r);
        end else if (pick_l) begin
          wdata = rd_a;
          idx_d = IW'(child_l);
        end
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= CFG_W'(1);
      size_q      <= '0;
      rpt_q       <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      size_q      <= size_d;
      rpt_q       <= rpt_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    cur_val_q <= cur_val_d;
    cur_run_q <= cur_run_d;
    exh_q     <= exh_d;
    out_val_q <= out_val_d;
    out_run_q <= out_run_d;
    out_fin_q <= out_fin_d;
  end

  assign out_valid_o    = out_valid_q;
  assign merged_value_o = out_val_q;
  assign source_run_o   = out_run_q;
  assign finished_o     = out_fin_q;

endmodule

`default_nettype wire

FILE: hw/rtl/kwhm_ctrl.sv
// ----------------------------------------------------------------------------
// kwhm_ctrl
// Sequencer of the heap merge: takes one item, pushes a present one (sift-up),
// counts the report; after the fill, pops the root (sift-down) or finishes.
// ----------------------------------------------------------------------------
`default_nettype none

module kwhm_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire kwhm_pkg::dp_status_t status_i,
  output kwhm_pkg::dp_op_e          op_o
);

  import kwhm_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        in_xfer;

  assign in_stall_o = state_q != ST_IDLE;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && !status_i.done) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        state_d = status_i.push_ok ? ST_SU_RD : ST_RPT;
      end
      ST_SU_RD: begin
        state_d = status_i.idx_zero ? ST_RPT : ST_SU_CMP;
      end
      ST_SU_CMP: begin
        state_d = status_i.up_less ? ST_SU_RD : ST_RPT;
      end
      ST_RPT: begin
        if (!status_i.rpt_last) begin
          state_d = ST_IDLE;
        end else if (status_i.heap_empty) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_POP_RD;
        end
      end
      ST_FIN: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_POP_RD: begin
        if (status_i.out_free) begin
          state_d = ST_POP_LD;
        end
      end
      ST_POP_LD: begin
        state_d = status_i.last_pop ? ST_IDLE : ST_SD_RD;
      end
      ST_SD_RD: begin
        state_d = ST_SD_CMP;
      end
      ST_SD_CMP: begin
        state_d = status_i.sd_stay ? ST_IDLE : ST_SD_RD;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // operation issued to the datapath
  always_comb begin
    op_o = OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && !status_i.done) begin
          op_o = OP_LOAD;
        end
      end
      ST_PUSH: begin
        if (status_i.push_ok) begin
          op_o = OP_PUSH_INIT;
        end
      end
      ST_SU_RD:  op_o = OP_SU_RD;
      ST_SU_CMP: op_o = OP_SU_CMP;
      ST_RPT:    op_o = OP_RPT;
      ST_FIN: begin
        if (status_i.out_free) begin
          op_o = OP_FIN;
        end
      end
      ST_POP_RD: op_o = OP_POP_RD;
      ST_POP_LD: op_o = OP_POP_LD;
      ST_SD_RD:  op_o = OP_SD_RD;
      ST_SD_CMP: op_o = OP_SD_CMP;
      default:   op_o = OP_NONE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/k_way_heap_merge.sv
// ----------------------------------------------------------------------------
// k_way_heap_merge
// Merges up to MAX_RUNS sorted runs into one ascending stream with a min-heap.
// ----------------------------------------------------------------------------
// Write the number of runs to cfg_wdata_i, then send one head report per run
// (its first element, or run_exhausted_i set for an empty run). After the last
// report, and after each later item, the smallest (value, run) pair goes out;
// equal values leave lowest run first. Each later item refills or exhausts the
// run given in source_run_o. When the heap runs dry one result with
// finished_o set is sent and further items are taken and dropped until reset.
// Items are handled one at a time. Each item is taken, set up for its push
// and its report counted; its sift-up reads and compares against each parent
// until it stops or reaches the root. When it produces an element, the root
// and last entry are read and the result loaded, then the sift-down reads and
// compares the children of each level while entries remain; the finished
// result is loaded alone. A stalled output holds the item until the previous
// result has left. Each compare waits on the registered read of the single
// heap RAM.
`default_nettype none

module k_way_heap_merge #(
  parameter int MAX_RUNS   = 16,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration
  input  wire logic                         cfg_we_i,
  input  wire logic [4:0]                   cfg_wdata_i,
  // input channel
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [3:0]                   run_index_i,
  input  wire logic signed [VALUE_BITS-1:0] run_value_i,
  input  wire logic                         run_exhausted_i,
  // output channel
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic signed [VALUE_BITS-1:0]      merged_value_o,
  output logic [3:0]                        source_run_o,
  output logic                              finished_o
);

  import kwhm_pkg::*;

  dp_op_e     dp_op;
  dp_status_t dp_status;

  kwhm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .op_o       (dp_op)
  );

  kwhm_datapath #(
    .MAX_RUNS   (MAX_RUNS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .run_index_i     (run_index_i),
    .run_value_i     (run_value_i),
    .run_exhausted_i (run_exhausted_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .merged_value_o  (merged_value_o),
    .source_run_o    (source_run_o),
    .finished_o      (finished_o),
    .op_i            (dp_op),
    .status_o        (dp_status)
  );

  // an item is captured only on an input transfer
  a_load_on_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_op == OP_LOAD) |-> (in_valid_i && !in_stall_o))
    else $error("item captured without input transfer");

  // a popped element never overwrites a pending result
  a_pop_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_op == OP_POP_LD) |-> !out_valid_o)
    else $error("pop loads an occupied output slot");

  // the finished result never overwrites a pending result
  a_fin_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_op == OP_FIN) |-> dp_status.out_free)
    else $error("finish loads an occupied output slot");

  // nothing is produced once the merge has finished and drained
  a_quiet_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_status.done && !out_valid_o) |=> !out_valid_o)
    else $error("result produced after finish");

endmodule

`default_nettype wire
